// File: rtl/lzss_pkg.sv
// Shared types and constants for the LZSS window decoder.
package lzss_pkg;

	localparam int WIN_BITS = 12;
	localparam logic [WIN_BITS-1:0] WIN_LAST = 12'hFFF;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 24;

	// Window layout of the pattern table fill.
	localparam logic [3:0] PAT_REPEAT_LAST = 4'h0C;   // each value appears 0x0D times
	localparam logic [WIN_BITS-1:0] PAT_RAMP_UP = 12'hD00;
	localparam logic [WIN_BITS-1:0] PAT_RAMP_DOWN = 12'hE00;
	localparam logic [WIN_BITS-1:0] PAT_ZEROS = 12'hF00;
	localparam logic [WIN_BITS-1:0] PAT_SPACES = 12'hF80;
	localparam logic [7:0] PAT_SPACE_BYTE = 8'h20;

	localparam logic [7:0] RST_FILL_VALUE = 8'd32;
	localparam logic [WIN_BITS-1:0] RST_START_OFFSET = 12'd4078;
	localparam logic [CFG_DATA_BITS-1:0] RST_OUT_LIMIT = 24'hFFFFFF;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_BYTE  = 2'd1,
		CMD_END   = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EARLY_END = 2'd1,
		ST_BAD_REF   = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		MODE_FILL    = 2'd0,
		MODE_ZERO    = 2'd1,
		MODE_PATTERN = 2'd2,
		MODE_ZERO_B  = 2'd3
	} init_mode_t;

	typedef enum logic [1:0] {
		LAYOUT_HL = 2'd0,
		LAYOUT_HH = 2'd1,
		LAYOUT_LH = 2'd2,
		LAYOUT_LL = 2'd3
	} layout_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_BIT_ORDER   = 3'd0,
		REG_LAYOUT      = 3'd1,
		REG_BIG_ENDIAN  = 3'd2,
		REG_ZERO_END    = 3'd3,
		REG_INIT_MODE   = 3'd4,
		REG_FILL_VALUE  = 3'd5,
		REG_START       = 3'd6,
		REG_OUT_LIMIT   = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		FSM_FILL,
		FSM_IDLE,
		FSM_COPY
	} fsm_t;

endpackage

// File: rtl/lzss_configurable_decoder_unit.sv
// Top level of the LZSS window decoder: window memory, control and output register.
//
// The block takes one command word at a time on the input channel (in_valid/in_stall):
// a start command, a compressed byte, or an end-of-input marker. It returns decompressed
// bytes and one final status word on the output channel (out_valid/out_stall); last marks
// the final word caused by an input word. Configuration registers are written on the
// cfg channel, which is always ready; the user must write them only while the block is
// idle, as the block itself does not enforce it. A start command, and reset itself,
// run a fill pass over the 4096-byte window, one entry a cycle, with in_stall high.
// A literal's byte sits in the output register at the next edge. A reference first
// issues the window read for its first byte, then copies one byte per cycle while
// the output is not stalled, set by the single read port of the window memory.
// The output register decouples the two sides: a new word is accepted while a finished
// word still waits, as long as that word is taken in the same cycle or the register is
// empty. When the receiver stalls, the output word holds and the copy pauses in place.
module lzss_configurable_decoder_unit #(
	parameter int MATCH_THRESHOLD = 2,
	parameter int COUNT_BITS = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] cmd,
	input  logic [7:0] in_byte,
	output logic out_valid,
	input  logic out_stall,
	output logic kind,
	output logic [7:0] out_byte,
	output logic [1:0] status,
	output logic [COUNT_BITS-1:0] bytes_written,
	output logic last,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [lzss_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [lzss_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	localparam int WB = lzss_pkg::WIN_BITS;
	localparam int LEN_BITS = $clog2(MATCH_THRESHOLD + 17);
	localparam int CMPW = COUNT_BITS + WB;

	// Configuration registers.
	logic bit_order_q, big_end_q, zero_end_q;
	logic [1:0] layout_q, init_mode_q;
	logic [7:0] fill_val_q;
	logic [WB-1:0] start_off_q;
	logic [COUNT_BITS-1:0] limit_q;

	// Decoder state.
	lzss_pkg::fsm_t state_q, state_d;
	logic [WB-1:0] fill_addr_q, fill_addr_d;
	logic [7:0] pat_val_q, pat_val_d;
	logic [3:0] pat_rep_q, pat_rep_d;
	logic [WB-1:0] wp_q, wp_d;
	logic [7:0] flag_q, flag_d;
	logic [3:0] flags_left_q, flags_left_d;
	logic [7:0] held_q, held_d;
	logic held_v_q, held_v_d;
	logic [COUNT_BITS-1:0] cnt_q, cnt_d;
	logic stopped_q, stopped_d;
	logic [WB-1:0] src_q, src_d;
	logic [LEN_BITS-1:0] rem_q, rem_d;
	logic rdv_s1, rdv_d;
	logic fwd_hit_s1, fwd_hit_d;
	logic [7:0] fwd_data_s1, fwd_data_d;

	// Output register.
	logic out_valid_q, kind_q, last_q;
	logic [7:0] out_byte_q;
	logic [1:0] status_q;
	logic [COUNT_BITS-1:0] bw_q;

	// Window memory.
	logic [7:0] window_mem [0:(1<<WB)-1];
	logic we;
	logic [WB-1:0] waddr, raddr;
	logic [7:0] wdata, rdata_q;

	// Result produced this cycle.
	logic o_load, o_kind, o_last;
	logic [7:0] o_byte;
	logic [1:0] o_status;
	logic [COUNT_BITS-1:0] o_cnt;

	logic slot_free, in_acc, cur_flag, full, emit;
	logic [7:0] ri, rj, copy_byte, fill_data;
	logic [WB-1:0] pos, back;
	logic [3:0] nib;
	logic [LEN_BITS-1:0] len;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall = !((state_q == lzss_pkg::FSM_IDLE) && slot_free);
	assign in_acc = in_valid && !in_stall;
	assign cur_flag = bit_order_q ? flag_q[7] : flag_q[0];
	assign full = cnt_q >= limit_q;
	assign emit = rdv_s1 && slot_free;
	assign copy_byte = fwd_hit_s1 ? fwd_data_s1 : rdata_q;
	assign cfg_ready = 1'b1;

	// Reference fields: i is the low byte, j the high byte.
	assign ri = big_end_q ? in_byte : held_q;
	assign rj = big_end_q ? held_q : in_byte;
	always_comb begin
		unique case (lzss_pkg::layout_t'(layout_q))
			lzss_pkg::LAYOUT_HH: begin
				pos = {rj[3:0], ri};
				nib = rj[7:4];
			end
			lzss_pkg::LAYOUT_LH: begin
				pos = {rj, ri[3:0]};
				nib = ri[7:4];
			end
			lzss_pkg::LAYOUT_LL: begin
				pos = {rj, ri[7:4]};
				nib = ri[3:0];
			end
			default: begin
				pos = {rj[7:4], ri};
				nib = rj[3:0];
			end
		endcase
	end
	assign len = LEN_BITS'(nib) + LEN_BITS'(MATCH_THRESHOLD + 1);
	assign back = wp_q - pos;

	// Data written during the fill pass.
	always_comb begin
		unique case (lzss_pkg::init_mode_t'(init_mode_q))
			lzss_pkg::MODE_FILL: fill_data = fill_val_q;
			lzss_pkg::MODE_PATTERN: begin
				if (fill_addr_q < lzss_pkg::PAT_RAMP_UP) begin
					fill_data = pat_val_q;
				end else if (fill_addr_q < lzss_pkg::PAT_RAMP_DOWN) begin
					fill_data = fill_addr_q[7:0];
				end else if (fill_addr_q < lzss_pkg::PAT_ZEROS) begin
					fill_data = ~fill_addr_q[7:0];
				end else if (fill_addr_q < lzss_pkg::PAT_SPACES) begin
					fill_data = 8'h00;
				end else begin
					fill_data = lzss_pkg::PAT_SPACE_BYTE;
				end
			end
			default: fill_data = 8'h00;
		endcase
	end

	always_comb begin
		state_d = state_q;
		fill_addr_d = fill_addr_q;
		pat_val_d = pat_val_q;
		pat_rep_d = pat_rep_q;
		wp_d = wp_q;
		flag_d = flag_q;
		flags_left_d = flags_left_q;
		held_d = held_q;
		held_v_d = held_v_q;
		cnt_d = cnt_q;
		stopped_d = stopped_q;
		src_d = src_q;
		rem_d = rem_q;
		rdv_d = rdv_s1;
		fwd_hit_d = fwd_hit_s1;
		fwd_data_d = fwd_data_s1;
		we = 1'b0;
		waddr = wp_q;
		wdata = in_byte;
		raddr = src_q;
		o_load = 1'b0;
		o_kind = 1'b0;
		o_byte = 8'h00;
		o_status = lzss_pkg::ST_OK;
		o_cnt = cnt_q;
		o_last = 1'b1;

		unique case (state_q)
			lzss_pkg::FSM_FILL: begin
				we = 1'b1;
				waddr = fill_addr_q;
				wdata = fill_data;
				fill_addr_d = fill_addr_q + 1'b1;
				if (pat_rep_q == lzss_pkg::PAT_REPEAT_LAST) begin
					pat_rep_d = 4'd0;
					pat_val_d = pat_val_q + 1'b1;
				end else begin
					pat_rep_d = pat_rep_q + 1'b1;
				end
				if (fill_addr_q == lzss_pkg::WIN_LAST) begin
					state_d = lzss_pkg::FSM_IDLE;
				end
			end
			lzss_pkg::FSM_IDLE: begin
				if (in_acc) begin
					priority if (lzss_pkg::cmd_t'(cmd) == lzss_pkg::CMD_START) begin
						state_d = lzss_pkg::FSM_FILL;
						fill_addr_d = '0;
						pat_val_d = 8'h00;
						pat_rep_d = 4'd0;
						wp_d = start_off_q;
						flag_d = 8'h00;
						flags_left_d = 4'd0;
						held_d = 8'h00;
						held_v_d = 1'b0;
						cnt_d = '0;
						stopped_d = 1'b0;
					end else if (stopped_q || lzss_pkg::cmd_t'(cmd) == lzss_pkg::CMD_NONE) begin
						// After a stop nothing is done until the next start; a none command does nothing.
					end else if (lzss_pkg::cmd_t'(cmd) == lzss_pkg::CMD_END) begin
						o_load = 1'b1;
						o_kind = 1'b1;
						o_status = (flags_left_q != 4'd0 && (cur_flag || held_v_q)) ?
							lzss_pkg::ST_EARLY_END : lzss_pkg::ST_OK;
						stopped_d = 1'b1;
					end else if (flags_left_q == 4'd0) begin
						flag_d = in_byte;
						flags_left_d = 4'd8;
					end else if (cur_flag) begin
						o_load = 1'b1;
						if (full) begin
							o_kind = 1'b1;
							o_status = lzss_pkg::ST_FULL;
							stopped_d = 1'b1;
						end else begin
							we = 1'b1;
							o_byte = in_byte;
							o_cnt = cnt_q + 1'b1;
							cnt_d = cnt_q + 1'b1;
							wp_d = wp_q + 1'b1;
							flag_d = bit_order_q ? {flag_q[6:0], 1'b0} : {1'b0, flag_q[7:1]};
							flags_left_d = flags_left_q - 1'b1;
						end
					end else if (!held_v_q) begin
						held_d = in_byte;
						held_v_d = 1'b1;
					end else begin
						held_v_d = 1'b0;
						if (zero_end_q && ri == 8'h00 && rj == 8'h00) begin
							o_load = 1'b1;
							o_kind = 1'b1;
							o_status = lzss_pkg::ST_OK;
							stopped_d = 1'b1;
						end else if (init_mode_q[0] && !init_mode_q[1] ?
								(CMPW'(back) > CMPW'(cnt_q)) : 1'b0) begin
							o_load = 1'b1;
							o_kind = 1'b1;
							o_status = lzss_pkg::ST_BAD_REF;
							stopped_d = 1'b1;
						end else if (init_mode_q == lzss_pkg::MODE_ZERO_B &&
								CMPW'(back) > CMPW'(cnt_q)) begin
							o_load = 1'b1;
							o_kind = 1'b1;
							o_status = lzss_pkg::ST_BAD_REF;
							stopped_d = 1'b1;
						end else begin
							state_d = lzss_pkg::FSM_COPY;
							raddr = pos;
							src_d = pos;
							rem_d = len;
							rdv_d = 1'b1;
							fwd_hit_d = 1'b0;
						end
					end
				end
			end
			lzss_pkg::FSM_COPY: begin
				if (emit) begin
					o_load = 1'b1;
					if (full) begin
						o_kind = 1'b1;
						o_status = lzss_pkg::ST_FULL;
						stopped_d = 1'b1;
						state_d = lzss_pkg::FSM_IDLE;
						rdv_d = 1'b0;
					end else begin
						we = 1'b1;
						wdata = copy_byte;
						o_byte = copy_byte;
						o_cnt = cnt_q + 1'b1;
						cnt_d = cnt_q + 1'b1;
						wp_d = wp_q + 1'b1;
						rem_d = rem_q - 1'b1;
						o_last = (rem_q == LEN_BITS'(1));
						src_d = src_q + 1'b1;
						raddr = src_q + 1'b1;
						// The byte written now is not yet in the memory for this read.
						fwd_hit_d = (src_q + 1'b1) == wp_q;
						fwd_data_d = copy_byte;
						if (rem_q == LEN_BITS'(1)) begin
							state_d = lzss_pkg::FSM_IDLE;
							rdv_d = 1'b0;
							flag_d = bit_order_q ? {flag_q[6:0], 1'b0} : {1'b0, flag_q[7:1]};
							flags_left_d = flags_left_q - 1'b1;
						end
					end
				end
			end
			default: state_d = lzss_pkg::FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			window_mem[waddr] <= wdata;
		end
		rdata_q <= window_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_order_q <= 1'b0;
			layout_q <= lzss_pkg::LAYOUT_HL;
			big_end_q <= 1'b0;
			zero_end_q <= 1'b0;
			init_mode_q <= lzss_pkg::MODE_FILL;
			fill_val_q <= lzss_pkg::RST_FILL_VALUE;
			start_off_q <= lzss_pkg::RST_START_OFFSET;
			limit_q <= COUNT_BITS'(lzss_pkg::RST_OUT_LIMIT);
		end else if (cfg_valid && cfg_ready) begin
			unique case (lzss_pkg::reg_idx_t'(cfg_index))
				lzss_pkg::REG_BIT_ORDER: bit_order_q <= cfg_data[0];
				lzss_pkg::REG_LAYOUT: layout_q <= cfg_data[1:0];
				lzss_pkg::REG_BIG_ENDIAN: big_end_q <= cfg_data[0];
				lzss_pkg::REG_ZERO_END: zero_end_q <= cfg_data[0];
				lzss_pkg::REG_INIT_MODE: init_mode_q <= cfg_data[1:0];
				lzss_pkg::REG_FILL_VALUE: fill_val_q <= cfg_data[7:0];
				lzss_pkg::REG_START: start_off_q <= cfg_data[WB-1:0];
				lzss_pkg::REG_OUT_LIMIT: limit_q <= COUNT_BITS'(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lzss_pkg::FSM_FILL;
			fill_addr_q <= '0;
			pat_val_q <= 8'h00;
			pat_rep_q <= 4'd0;
			wp_q <= lzss_pkg::RST_START_OFFSET;
			flag_q <= 8'h00;
			flags_left_q <= 4'd0;
			held_q <= 8'h00;
			held_v_q <= 1'b0;
			cnt_q <= '0;
			stopped_q <= 1'b0;
			rdv_s1 <= 1'b0;
			fwd_hit_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_addr_q <= fill_addr_d;
			pat_val_q <= pat_val_d;
			pat_rep_q <= pat_rep_d;
			wp_q <= wp_d;
			flag_q <= flag_d;
			flags_left_q <= flags_left_d;
			held_q <= held_d;
			held_v_q <= held_v_d;
			cnt_q <= cnt_d;
			stopped_q <= stopped_d;
			rdv_s1 <= rdv_d;
			fwd_hit_s1 <= fwd_hit_d;
			if (o_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		src_q <= src_d;
		rem_q <= rem_d;
		fwd_data_s1 <= fwd_data_d;
		if (o_load) begin
			kind_q <= o_kind;
			out_byte_q <= o_byte;
			status_q <= o_status;
			bw_q <= o_cnt;
			last_q <= o_last;
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign out_byte = out_byte_q;
	assign status = status_q;
	assign bytes_written = bw_q;
	assign last = last_q;

endmodule

// File: rtl/lzss_checker.sv
// Port-level assertions for the LZSS window decoder and their bind.
module lzss_checker #(
	parameter int COUNT_BITS = 24
) (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic kind,
	input logic [7:0] out_byte,
	input logic [1:0] status,
	input logic [COUNT_BITS-1:0] bytes_written,
	input logic last
);

	// A stalled output word holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(kind)
		&& $stable(bytes_written))
		else $error("stalled output word changed");

	// A status word always closes its input's results.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind |-> last)
		else $error("status word without last");

	// Byte words carry status ok, status words carry a zero byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !kind |-> status == 2'd0)
		else $error("byte word with nonzero status");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind |-> out_byte == 8'h00)
		else $error("status word with nonzero byte");

endmodule

bind lzss_configurable_decoder_unit lzss_checker #(.COUNT_BITS(COUNT_BITS)) u_lzss_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.kind(kind),
	.out_byte(out_byte),
	.status(status),
	.bytes_written(bytes_written),
	.last(last)
);
